@@ rtl/c8x_pkg.sv @@
`timescale 1ns / 1ps
package c8x_pkg;

    typedef enum logic [1:0] {
        ST_EXEC = 2'd0,
        ST_LOAD = 2'd1,
        ST_HALT = 2'd2
    } status_t;

    localparam logic KIND_LOAD = 1'b0;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
        logic [15:0] pc;
        logic        z;
        logic        s;
        logic        p;
        logic        cy;
    } cpu_regs_t;

    typedef struct packed {
        logic        ok;
        logic        need_mem;
        logic        mem_we;
        logic [15:0] mem_addr;
        logic [7:0]  mem_wdata;
    } exec_ctl_t;

    // Operand select codes in the low or middle opcode field.
    localparam logic [2:0] SEL_M = 3'd6;
    localparam logic [2:0] SEL_A = 3'd7;

    // ALU group function codes.
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_ADC = 3'd1;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_SBB = 3'd3;
    localparam logic [2:0] ALU_ANA = 3'd4;
    localparam logic [2:0] ALU_XRA = 3'd5;
    localparam logic [2:0] ALU_ORA = 3'd6;

    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_NOP8  = 8'h08;
    localparam logic [7:0] OP_MOVAA = 8'h7f;
    localparam logic [7:0] OP_LXIB  = 8'h01;
    localparam logic [7:0] OP_STAXB = 8'h02;
    localparam logic [7:0] OP_LDAXB = 8'h0a;
    localparam logic [7:0] OP_LDAXD = 8'h1a;
    localparam logic [7:0] OP_INXB  = 8'h03;
    localparam logic [7:0] OP_INXD  = 8'h13;
    localparam logic [7:0] OP_INXH  = 8'h23;
    localparam logic [7:0] OP_INXSP = 8'h33;
    localparam logic [7:0] OP_DCXB  = 8'h0b;
    localparam logic [7:0] OP_DCXD  = 8'h1b;
    localparam logic [7:0] OP_DCXH  = 8'h2b;
    localparam logic [7:0] OP_DCXSP = 8'h3b;
    localparam logic [7:0] OP_MVIB  = 8'h06;
    localparam logic [7:0] OP_RLC   = 8'h07;
    localparam logic [7:0] OP_DADB  = 8'h09;
    localparam logic [7:0] OP_DADD  = 8'h19;
    localparam logic [7:0] OP_DADH  = 8'h29;
    localparam logic [7:0] OP_DADSP = 8'h39;
    localparam logic [7:0] OP_MOVBC = 8'h41;
    localparam logic [7:0] OP_MOVBD = 8'h42;
    localparam logic [7:0] OP_MOVBE = 8'h43;
    localparam logic [7:0] OP_MOVBH = 8'h44;
    localparam logic [7:0] OP_MOVBL = 8'h45;
    localparam logic [7:0] OP_MOVBA = 8'h47;
    localparam logic [7:0] OP_JMP   = 8'hc3;
    localparam logic [7:0] OP_JNZ   = 8'hc2;
    localparam logic [7:0] OP_ADI   = 8'hc6;
    localparam logic [7:0] OP_SUI   = 8'hd6;

endpackage

@@ rtl/c8x_ram.sv @@
`timescale 1ns / 1ps
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/c8x_exec.sv @@
`timescale 1ns / 1ps
module c8x_exec (
    input  c8x_pkg::cpu_regs_t cur,
    input  logic [7:0]         op,
    input  logic [7:0]         b1,
    input  logic [7:0]         b2,
    input  logic [7:0]         mdata,
    output c8x_pkg::cpu_regs_t nxt,
    output c8x_pkg::exec_ctl_t ctl
);
    import c8x_pkg::*;

    logic [7:0]  src_lo;
    logic [7:0]  src_mid;
    logic [7:0]  alu_x;
    logic [2:0]  alu_op;
    logic        cin;
    logic [8:0]  sum9;
    logic [8:0]  dif9;
    logic [7:0]  res;
    logic        res_cy;
    logic [7:0]  incdec;
    logic [15:0] hl;
    logic [15:0] dad_src;
    logic [16:0] dad_sum;
    logic [15:0] target;

    function automatic logic [7:0] pick(input cpu_regs_t r, input logic [2:0] idx,
                                        input logic [7:0] m);
        logic [7:0] v;
        case (idx)
            3'd0:    v = r.b;
            3'd1:    v = r.c;
            3'd2:    v = r.d;
            3'd3:    v = r.e;
            3'd4:    v = r.h;
            3'd5:    v = r.l;
            SEL_M:   v = m;
            default: v = r.a;
        endcase
        return v;
    endfunction

    assign hl      = {cur.h, cur.l};
    assign target  = {b2, b1};
    assign src_lo  = pick(cur, op[2:0], mdata);
    assign src_mid = pick(cur, op[5:3], mdata);
    assign incdec  = op[0] ? (src_mid - 8'd1) : (src_mid + 8'd1);

    // ADI and SUI reuse the register ALU with the immediate byte.
    always_comb
    begin
        if (op == OP_ADI)
        begin
            alu_op = ALU_ADD;
            alu_x  = b1;
        end
        else if (op == OP_SUI)
        begin
            alu_op = ALU_SUB;
            alu_x  = b1;
        end
        else
        begin
            alu_op = op[5:3];
            alu_x  = src_lo;
        end
    end

    assign cin  = (alu_op == ALU_ADC || alu_op == ALU_SBB) ? cur.cy : 1'b0;
    assign sum9 = {1'b0, cur.a} + {1'b0, alu_x} + {8'd0, cin};
    assign dif9 = {1'b0, cur.a} - {1'b0, alu_x} - {8'd0, cin};

    always_comb
    begin
        case (alu_op)
            ALU_ADD, ALU_ADC:
            begin
                res    = sum9[7:0];
                res_cy = sum9[8];
            end
            ALU_SUB, ALU_SBB:
            begin
                res    = dif9[7:0];
                res_cy = dif9[8];
            end
            ALU_ANA:
            begin
                res    = cur.a & alu_x;
                res_cy = 1'b0;
            end
            ALU_XRA:
            begin
                res    = cur.a ^ alu_x;
                res_cy = 1'b0;
            end
            default:
            begin
                res    = cur.a | alu_x;
                res_cy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (op[5:4])
            2'd0:    dad_src = {cur.b, cur.c};
            2'd1:    dad_src = {cur.d, cur.e};
            2'd2:    dad_src = hl;
            default: dad_src = cur.sp;
        endcase
    end
    assign dad_sum = {1'b0, hl} + {1'b0, dad_src};

    always_comb
    begin
        nxt    = cur;
        nxt.pc = cur.pc + 16'd1;
        ctl    = '0;
        ctl.ok = 1'b1;
        if (op[7:6] == 2'b10 && op[5:3] != 3'd7)
        begin
            ctl.need_mem = (op[2:0] == SEL_M);
            ctl.mem_addr = hl;
            nxt.a  = res;
            nxt.cy = res_cy;
            nxt.z  = (res == 8'd0);
            nxt.s  = res[7];
            nxt.p  = ~^res;
        end
        else if (op[7:6] == 2'b00 && (op[2:0] == 3'd4 || op[2:0] == 3'd5))
        begin
            nxt.z = (incdec == 8'd0);
            nxt.s = incdec[7];
            nxt.p = ~^incdec;
            case (op[5:3])
                3'd0: nxt.b = incdec;
                3'd1: nxt.c = incdec;
                3'd2: nxt.d = incdec;
                3'd3: nxt.e = incdec;
                3'd4: nxt.h = incdec;
                3'd5: nxt.l = incdec;
                SEL_M:
                begin
                    ctl.need_mem  = 1'b1;
                    ctl.mem_we    = 1'b1;
                    ctl.mem_addr  = hl;
                    ctl.mem_wdata = incdec;
                end
                default: nxt.a = incdec;
            endcase
        end
        else
        begin
            unique case (op)
                OP_NOP, OP_NOP8, OP_MOVAA: ;
                OP_LXIB:
                begin
                    nxt.c  = b1;
                    nxt.b  = b2;
                    nxt.pc = cur.pc + 16'd3;
                end
                OP_STAXB:
                begin
                    ctl.mem_we    = 1'b1;
                    ctl.mem_addr  = {cur.b, cur.c};
                    ctl.mem_wdata = cur.a;
                end
                OP_LDAXB:
                begin
                    ctl.need_mem = 1'b1;
                    ctl.mem_addr = {cur.b, cur.c};
                    nxt.a        = mdata;
                end
                OP_LDAXD:
                begin
                    ctl.need_mem = 1'b1;
                    ctl.mem_addr = {cur.d, cur.e};
                    nxt.a        = mdata;
                end
                OP_INXB:  {nxt.b, nxt.c} = {cur.b, cur.c} + 16'd1;
                OP_INXD:  {nxt.d, nxt.e} = {cur.d, cur.e} + 16'd1;
                OP_INXH:  {nxt.h, nxt.l} = hl + 16'd1;
                OP_INXSP: nxt.sp = cur.sp + 16'd1;
                OP_DCXB:  {nxt.b, nxt.c} = {cur.b, cur.c} - 16'd1;
                OP_DCXD:  {nxt.d, nxt.e} = {cur.d, cur.e} - 16'd1;
                OP_DCXH:  {nxt.h, nxt.l} = hl - 16'd1;
                OP_DCXSP: nxt.sp = cur.sp - 16'd1;
                OP_MVIB:
                begin
                    nxt.b  = b1;
                    nxt.pc = cur.pc + 16'd2;
                end
                OP_RLC:
                begin
                    nxt.cy = cur.a[7];
                    nxt.a  = {cur.a[6:0], cur.a[7]};
                end
                OP_DADB, OP_DADD, OP_DADH, OP_DADSP:
                begin
                    {nxt.h, nxt.l} = dad_sum[15:0];
                    nxt.cy         = dad_sum[16];
                end
                OP_MOVBC, OP_MOVBD, OP_MOVBE, OP_MOVBH, OP_MOVBL, OP_MOVBA:
                    nxt.b = src_lo;
                OP_JMP: nxt.pc = target;
                OP_JNZ: nxt.pc = cur.z ? (cur.pc + 16'd3) : target;
                OP_ADI, OP_SUI:
                begin
                    nxt.a  = res;
                    nxt.cy = res_cy;
                    nxt.z  = (res == 8'd0);
                    nxt.s  = res[7];
                    nxt.p  = ~^res;
                    nxt.pc = cur.pc + 16'd2;
                end
                default: ctl.ok = 1'b0;
            endcase
        end
    end

endmodule

@@ rtl/cpu8080_subset_execute_unit.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Signals
// in        request    in_valid, in_ready, kind, load_addr, load_data
// out       result     out_valid, out_ready, out_status, out_pc, out_a, out_bc,
//                      out_de, out_hl, out_sp, out_zero, out_sign, out_parity, out_carry
//
// A load request writes memory and is answered without leaving idle; an execute
// steps through the fetch states S_F1, S_F2 and S_F3, then S_MEM when it reads a
// data byte (operand M, LDAX, INR/DCR M). The single memory port sets this order:
// three fetch reads, then an optional data read with its write-back.
// An execute while halted is answered from idle. Reset clears the CPU registers and
// the halt flag; memory contents are undefined until loaded. A new request is taken
// while the unit is idle, once the previous result has left the output register or is being taken in the same cycle.
module cpu8080_subset_execute_unit #(
    parameter int ADDR_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [15:0]            load_addr,
    input  logic [7:0]             load_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_status,
    output logic [15:0]            out_pc,
    output logic [7:0]             out_a,
    output logic [15:0]            out_bc,
    output logic [15:0]            out_de,
    output logic [15:0]            out_hl,
    output logic [15:0]            out_sp,
    output logic                   out_zero,
    output logic                   out_sign,
    output logic                   out_parity,
    output logic                   out_carry
);
    import c8x_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_F1, S_F2, S_F3, S_MEM} state_t;

    state_t     state_reg;
    cpu_regs_t  regs_reg;
    cpu_regs_t  regs_next;
    cpu_regs_t  nxt;
    exec_ctl_t  ctl;
    logic       halted_reg;
    logic [7:0] op_reg;
    logic [7:0] b1_reg;
    logic [7:0] b2_reg;
    logic [7:0] b2_in;
    logic       out_valid_reg;
    status_t    status_reg;
    status_t    status_next;
    logic       accept;
    logic       done;
    logic       ram_we;
    logic [15:0] ram_addr;
    logic [7:0] ram_wdata;
    logic [7:0] ram_rdata;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign b2_in    = (state_reg == S_F3) ? ram_rdata : b2_reg;

    c8x_exec u_exec (
        .cur   (regs_reg),
        .op    (op_reg),
        .b1    (b1_reg),
        .b2    (b2_in),
        .mdata (ram_rdata),
        .nxt   (nxt),
        .ctl   (ctl)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = regs_reg.pc;
        ram_wdata = load_data;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && kind == KIND_LOAD)
                begin
                    ram_we   = 1'b1;
                    ram_addr = load_addr;
                end
            end
            S_F1: ram_addr = regs_reg.pc + 16'd1;
            S_F2: ram_addr = regs_reg.pc + 16'd2;
            default:
            begin
                ram_addr  = ctl.mem_addr;
                ram_wdata = ctl.mem_wdata;
                ram_we    = ctl.mem_we && ((state_reg == S_MEM) || !ctl.need_mem);
            end
        endcase
    end

    c8x_ram #(
        .WIDTH (8),
        .DEPTH (1 << ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr[ADDR_BITS-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        done        = 1'b0;
        regs_next   = regs_reg;
        status_next = ST_EXEC;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        done        = 1'b1;
                        status_next = ST_LOAD;
                    end
                    else if (halted_reg)
                    begin
                        done        = 1'b1;
                        status_next = ST_HALT;
                    end
                end
            end
            S_F3, S_MEM:
            begin
                if (state_reg == S_MEM || !ctl.need_mem)
                begin
                    done        = 1'b1;
                    status_next = ctl.ok ? ST_EXEC : ST_HALT;
                    if (ctl.ok)
                    begin
                        regs_next = nxt;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            regs_reg      <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_EXEC;
        end
        else
        begin
            regs_reg <= regs_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
                if (state_reg != S_IDLE && !ctl.ok)
                begin
                    halted_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind != KIND_LOAD && !halted_reg)
                    begin
                        state_reg <= S_F1;
                    end
                end
                S_F1: state_reg <= S_F2;
                S_F2: state_reg <= S_F3;
                S_F3: state_reg <= ctl.need_mem ? S_MEM : S_IDLE;
                S_MEM: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_F1)
        begin
            op_reg <= ram_rdata;
        end
        if (state_reg == S_F2)
        begin
            b1_reg <= ram_rdata;
        end
        if (state_reg == S_F3)
        begin
            b2_reg <= ram_rdata;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_pc     = regs_reg.pc;
    assign out_a      = regs_reg.a;
    assign out_bc     = {regs_reg.b, regs_reg.c};
    assign out_de     = {regs_reg.d, regs_reg.e};
    assign out_hl     = {regs_reg.h, regs_reg.l};
    assign out_sp     = regs_reg.sp;
    assign out_zero   = regs_reg.z;
    assign out_sign   = regs_reg.s;
    assign out_parity = regs_reg.p;
    assign out_carry  = regs_reg.cy;

endmodule
